FILE: src/som_bmu_pkg.sv
// Shared types and constants of the self-organizing map best matching unit search.
package som_bmu_pkg;

  // Fixed field widths of the ports and of the configuration registers
  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;
  localparam int IDX_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int DIST_W  = 36;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int ROWS_REG_W = 4;
  localparam int COLS_REG_W = 4;
  localparam int LEN_REG_W  = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd2;

  // Reset values of the registers
  localparam logic [ROWS_REG_W-1:0] MAP_ROWS_RST = 4'd8;
  localparam logic [COLS_REG_W-1:0] MAP_COLS_RST = 4'd8;
  localparam logic [LEN_REG_W-1:0]  VEC_LEN_RST  = 5'd16;

  // Commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Tag of one element step through the shared unit
  typedef struct packed {
    logic valid;  // step carries data
    logic first;  // first element of a neuron
    logic last;   // last element of a neuron
    logic tail;   // last element of the last neuron
  } step_ctl_t;

  // Per-neuron sum handshake from the shared unit
  typedef struct packed {
    logic valid;  // a neuron sum is ready
    logic tail;   // it is the last neuron of the search
  } sum_ctl_t;

endpackage

FILE: src/som_bmu_store.sv
// Weight memory and sample buffer, each with one write port and a registered read port.
module som_bmu_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int SLEN  = 16,
  parameter int SW    = 4,
  parameter int VW    = 16
) (
  input  logic                 clk,
  input  logic                 weight_we,
  input  logic [AW-1:0]        weight_waddr,
  input  logic                 sample_we,
  input  logic [SW-1:0]        sample_waddr,
  input  logic signed [VW-1:0] wdata,
  input  logic [AW-1:0]        weight_raddr,
  input  logic [SW-1:0]        sample_raddr,
  output logic signed [VW-1:0] weight_rdata,
  output logic signed [VW-1:0] sample_rdata
);

  logic signed [VW-1:0] weight_mem [DEPTH];
  logic signed [VW-1:0] sample_mem [SLEN];

  // Weight memory
  always_ff @(posedge clk) begin
    if (weight_we) begin
      weight_mem[weight_waddr] <= wdata;
    end
    weight_rdata <= weight_mem[weight_raddr];
  end

  // Sample buffer
  always_ff @(posedge clk) begin
    if (sample_we) begin
      sample_mem[sample_waddr] <= wdata;
    end
    sample_rdata <= sample_mem[sample_raddr];
  end

endmodule

FILE: src/som_bmu_mac.sv
// Shared subtract, square and accumulate unit, one element per cycle.
module som_bmu_mac #(
  parameter int VW    = 16,
  parameter int ACC_W = 37,
  parameter int RW    = 3,
  parameter int CW    = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  som_bmu_pkg::step_ctl_t     step_ctl,
  input  logic [RW-1:0]              step_row,
  input  logic [CW-1:0]              step_col,
  input  logic signed [VW-1:0]       weight,
  input  logic signed [VW-1:0]       sample,
  output som_bmu_pkg::sum_ctl_t      sum_ctl,
  output logic [ACC_W-1:0]           sum,
  output logic [RW-1:0]              sum_row,
  output logic [CW-1:0]              sum_col
);
  import som_bmu_pkg::*;

  step_ctl_t ctl1, ctl2, ctl3;
  logic [RW-1:0] row1, row2, row3;
  logic [CW-1:0] col1, col2, col3;
  logic signed [VW:0] diff;
  logic [VW-1:0] mag2;
  logic [2*VW-1:0] sq3;
  logic [ACC_W:0] acc_add;
  logic [ACC_W-1:0] acc_next;

  // Control tags follow the data; stage 1 lines up with the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      sum_ctl <= '0;
    end else begin
      ctl1 <= step_ctl;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      sum_ctl.valid <= ctl3.valid && ctl3.last;
      sum_ctl.tail  <= ctl3.valid && ctl3.tail;
    end
  end

  // Magnitude of the difference
  always_comb begin
    diff = (VW+1)'(sample) - (VW+1)'(weight);
  end

  always_ff @(posedge clk) begin
    row1 <= step_row;
    col1 <= step_col;
    row2 <= row1;
    col2 <= col1;
    row3 <= row2;
    col3 <= col2;
    mag2 <= diff[VW] ? VW'(-diff) : VW'(diff);
    sq3  <= mag2 * mag2;
  end

  // Saturating accumulate
  always_comb begin
    acc_add = {1'b0, sum} + (ACC_W+1)'(sq3);
    if (ctl3.first) begin
      acc_next = ACC_W'(sq3);
    end else if (acc_add[ACC_W]) begin
      acc_next = '1;
    end else begin
      acc_next = acc_add[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl3.valid) begin
      sum     <= acc_next;
      sum_row <= row3;
      sum_col <= col3;
    end
  end

endmodule

FILE: src/som_bmu_ctrl.sv
// Sequencer: configuration registers, input handshake and the neuron/element walk.
module som_bmu_ctrl #(
  parameter int MAX_ROWS          = 8,
  parameter int MAX_COLS          = 8,
  parameter int MAX_VECTOR_LENGTH = 16,
  parameter int RW = 3,
  parameter int CW = 3,
  parameter int EW = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [som_bmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [som_bmu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               in_valid,
  input  logic                               cmd,
  input  logic                               last_element,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  som_bmu_pkg::sum_ctl_t              sum_ctl,
  output logic                               in_stall,
  output logic                               in_accept,
  output som_bmu_pkg::step_ctl_t             step_ctl,
  output logic [RW-1:0]                      step_row,
  output logic [CW-1:0]                      step_col,
  output logic [EW-1:0]                      step_elem,
  output logic                               load_out
);
  import som_bmu_pkg::*;

  state_t state, state_next;
  logic [ROWS_REG_W-1:0] map_rows;
  logic [COLS_REG_W-1:0] map_cols;
  logic [LEN_REG_W-1:0]  vector_length;
  logic [RW-1:0] rows_last;
  logic [CW-1:0] cols_last;
  logic [EW-1:0] elem_last;
  logic start;
  logic e_end, c_end, r_end;
  int rows_n, cols_n, len_n;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows      <= MAP_ROWS_RST;
      map_cols      <= MAP_COLS_RST;
      vector_length <= VEC_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_ROWS:      map_rows      <= cfg_data[ROWS_REG_W-1:0];
        CFG_MAP_COLS:      map_cols      <= cfg_data[COLS_REG_W-1:0];
        CFG_VECTOR_LENGTH: vector_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the registers into the built map
  always_comb begin
    rows_n = int'(map_rows);
    cols_n = int'(map_cols);
    len_n  = int'(vector_length);
    if (rows_n < 1) rows_n = 1;
    if (rows_n > MAX_ROWS) rows_n = MAX_ROWS;
    if (cols_n < 1) cols_n = 1;
    if (cols_n > MAX_COLS) cols_n = MAX_COLS;
    if (len_n < 1) len_n = 1;
    if (len_n > MAX_VECTOR_LENGTH) len_n = MAX_VECTOR_LENGTH;
    rows_last = RW'(rows_n - 1);
    cols_last = CW'(cols_n - 1);
    elem_last = EW'(len_n - 1);
  end

  assign in_accept = in_valid && !in_stall;
  assign start     = in_accept && (cmd == CMD_SAMPLE) && last_element;
  assign e_end     = (step_elem == elem_last);
  assign c_end     = (step_col == cols_last);
  assign r_end     = (step_row == rows_last);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_RUN;
      ST_RUN:   if (e_end && c_end && r_end) state_next = ST_DRAIN;
      ST_DRAIN: if (sum_ctl.valid && sum_ctl.tail) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall       = 1'b1;
    load_out       = 1'b0;
    step_ctl       = '0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN: begin
        step_ctl.valid = 1'b1;
        step_ctl.first = (step_elem == '0);
        step_ctl.last  = e_end;
        step_ctl.tail  = e_end && c_end && r_end;
      end
      ST_DRAIN: ;
      ST_DONE: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Element, column and row counters, row-major order
  always_ff @(posedge clk) begin
    if (rst) begin
      step_row  <= '0;
      step_col  <= '0;
      step_elem <= '0;
    end else if (state == ST_IDLE) begin
      step_row  <= '0;
      step_col  <= '0;
      step_elem <= '0;
    end else if (state == ST_RUN) begin
      if (!e_end) begin
        step_elem <= step_elem + 1'b1;
      end else begin
        step_elem <= '0;
        if (!c_end) begin
          step_col <= step_col + 1'b1;
        end else begin
          step_col <= '0;
          if (!r_end) begin
            step_row <= step_row + 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: src/som_best_matching_unit.sv
// Top level of the self-organizing map best matching unit search.
//
//   channel | signals                                             | direction
//   --------+-----------------------------------------------------+----------
//   input   | in_valid/in_stall, cmd, neuron_row, neuron_col,     | in
//           | element_index, element_value, last_element          |
//   output  | out_valid/out_stall, winner_row, winner_col,        | out
//           | best_distance                                       |
//   config  | cfg_we, cfg_index, cfg_data                         | in
//
// Load items and sample items without the last mark are taken while idle.
// A last sample element starts a search over rows*cols*length elements, one
// element per cycle through the single subtract-square-accumulate unit, followed
// by the memory read, the pipeline and the result load.
// in_stall is high for the whole search; a waiting result stalls only the next one.
// Reset is synchronous; memories are not cleared and hold garbage until written.
module som_best_matching_unit #(
  parameter int MAX_ROWS          = 8,
  parameter int MAX_COLS          = 8,
  parameter int MAX_VECTOR_LENGTH = 16,
  parameter int VALUE_WIDTH       = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [som_bmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [som_bmu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [som_bmu_pkg::ROW_W-1:0]      neuron_row,
  input  logic [som_bmu_pkg::COL_W-1:0]      neuron_col,
  input  logic [som_bmu_pkg::IDX_W-1:0]      element_index,
  input  logic signed [som_bmu_pkg::ELEM_W-1:0] element_value,
  input  logic                               last_element,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [som_bmu_pkg::ROW_W-1:0]      winner_row,
  output logic [som_bmu_pkg::COL_W-1:0]      winner_col,
  output logic [som_bmu_pkg::DIST_W-1:0]     best_distance
);
  import som_bmu_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS * MAX_VECTOR_LENGTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_RAW = 2 * VALUE_WIDTH + $clog2(MAX_VECTOR_LENGTH + 1);
  localparam int ACC_W = (ACC_RAW > 64) ? 64 : ACC_RAW;

  logic in_accept;
  logic load_out;
  step_ctl_t step_ctl;
  sum_ctl_t sum_ctl;
  logic [RW-1:0] step_row, sum_row, best_row;
  logic [CW-1:0] step_col, sum_col, best_col;
  logic [EW-1:0] step_elem;
  logic [ACC_W-1:0] sum, best_sum;
  logic signed [VALUE_WIDTH-1:0] value;
  logic signed [VALUE_WIDTH-1:0] weight_rdata, sample_rdata;
  logic weight_we, sample_we;
  logic [AW-1:0] weight_waddr, weight_raddr;
  logic [EW-1:0] sample_waddr;

  som_bmu_ctrl #(
    .MAX_ROWS          (MAX_ROWS),
    .MAX_COLS          (MAX_COLS),
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
    .RW (RW),
    .CW (CW),
    .EW (EW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .cmd          (cmd),
    .last_element (last_element),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sum_ctl      (sum_ctl),
    .in_stall     (in_stall),
    .in_accept    (in_accept),
    .step_ctl     (step_ctl),
    .step_row     (step_row),
    .step_col     (step_col),
    .step_elem    (step_elem),
    .load_out     (load_out)
  );

  // Element value at the working width: sign extend or wrap
  assign value = VALUE_WIDTH'(element_value);

  // Write decode; out-of-range writes are dropped
  always_comb begin
    weight_we = in_accept && (cmd == CMD_LOAD) && (int'(neuron_row) < MAX_ROWS)
                && (int'(neuron_col) < MAX_COLS)
                && (int'(element_index) < MAX_VECTOR_LENGTH);
    sample_we = in_accept && (cmd == CMD_SAMPLE)
                && (int'(element_index) < MAX_VECTOR_LENGTH);
    weight_waddr = AW'((int'(neuron_row) * MAX_COLS + int'(neuron_col))
                       * MAX_VECTOR_LENGTH + int'(element_index));
    sample_waddr = EW'(element_index);
    weight_raddr = AW'((int'(step_row) * MAX_COLS + int'(step_col))
                       * MAX_VECTOR_LENGTH + int'(step_elem));
  end

  som_bmu_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .SLEN  (MAX_VECTOR_LENGTH),
    .SW    (EW),
    .VW    (VALUE_WIDTH)
  ) u_store (
    .clk          (clk),
    .weight_we    (weight_we),
    .weight_waddr (weight_waddr),
    .sample_we    (sample_we),
    .sample_waddr (sample_waddr),
    .wdata        (value),
    .weight_raddr (weight_raddr),
    .sample_raddr (step_elem),
    .weight_rdata (weight_rdata),
    .sample_rdata (sample_rdata)
  );

  som_bmu_mac #(
    .VW    (VALUE_WIDTH),
    .ACC_W (ACC_W),
    .RW    (RW),
    .CW    (CW)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .step_ctl (step_ctl),
    .step_row (step_row),
    .step_col (step_col),
    .weight   (weight_rdata),
    .sample   (sample_rdata),
    .sum_ctl  (sum_ctl),
    .sum      (sum),
    .sum_row  (sum_row),
    .sum_col  (sum_col)
  );

  // Running minimum; neuron (0,0) always opens a search, ties keep the earlier one
  always_ff @(posedge clk) begin
    if (sum_ctl.valid) begin
      if ((sum_row == '0 && sum_col == '0) || (sum < best_sum)) begin
        best_sum <= sum;
        best_row <= sum_row;
        best_col <= sum_col;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      winner_row    <= ROW_W'(best_row);
      winner_col    <= COL_W'(best_col);
      best_distance <= DIST_W'(best_sum);
    end
  end

endmodule

FILE: bench/som_best_matching_unit_tb.sv
// Self-checking bench for the SOM best matching unit search, with a scoreboard class.
`timescale 1ns / 1ps

module som_best_matching_unit_tb;
  import som_bmu_pkg::*;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int MAX_LEN  = 16;
  localparam int SETTLE_CYCLES = 20;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [ELEM_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] VAL_MAX = 16'sh7FFF;

  // shapes of one sample sequence
  typedef enum int {
    SEQ_PLAIN,
    SEQ_EXTREME,
    SEQ_COPY,
    SEQ_TIE,
    SEQ_PARTIAL,
    SEQ_ABANDON
  } seq_kind_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] distance;
  } winner_t;

  // map settings per phase, as raw register data (some out of range on purpose)
  int unsigned phase_rows [7] = '{0, 8, 1, 2, 3, 8, 0};
  int unsigned phase_cols [7] = '{8, 31, 1, 3, 2, 2, 0};
  int unsigned phase_len  [7] = '{1, 0, 16, 20, 4, 2, 31};
  int unsigned phase_seqs [7] = '{10, 10, 3, 3, 8, 8, 3};
  seq_kind_t   phase_open [7] = '{SEQ_TIE, SEQ_PLAIN, SEQ_EXTREME, SEQ_COPY,
                                  SEQ_TIE, SEQ_PARTIAL, SEQ_EXTREME};

  // Scoreboard: mirrors the map and the sample, predicts each search
  class winner_board;
    logic signed [ELEM_W-1:0] weight [MAX_ROWS][MAX_COLS][MAX_LEN];
    logic signed [ELEM_W-1:0] sample [MAX_LEN];
    int unsigned rows_used;
    int unsigned cols_used;
    int unsigned len_used;
    winner_t     pending_winners [$];
    int unsigned errors;

    function new();
      rows_used = MAX_ROWS;
      cols_used = MAX_COLS;
      len_used  = MAX_LEN;
      errors    = 0;
    endfunction

    static function int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAP_ROWS:      rows_used = clamp_dim(data[ROWS_REG_W-1:0], MAX_ROWS);
        CFG_MAP_COLS:      cols_used = clamp_dim(data[COLS_REG_W-1:0], MAX_COLS);
        CFG_VECTOR_LENGTH: len_used  = clamp_dim(data[LEN_REG_W-1:0], MAX_LEN);
        default: ;
      endcase
    endfunction

    // row-major walk, strict compare so the first of equal sums wins
    function winner_t nearest_neuron();
      winner_t best;
      longint  best_sum;
      longint  sum;
      longint  diff;
      bit      have;
      have = 0;
      best = '0;
      best_sum = 0;
      for (int r = 0; r < rows_used; r++) begin
        for (int c = 0; c < cols_used; c++) begin
          sum = 0;
          for (int e = 0; e < len_used; e++) begin
            diff = longint'(sample[e]) - longint'(weight[r][c][e]);
            sum += diff * diff;
          end
          if (!have || sum < best_sum) begin
            best_sum = sum;
            best.row = r;
            best.col = c;
            have = 1;
          end
        end
      end
      best.distance = best_sum[DIST_W-1:0];
      return best;
    endfunction

    // accepted input transaction
    function void take_item(input logic c_cmd, input logic [ROW_W-1:0] c_row,
                            input logic [COL_W-1:0] c_col, input logic [IDX_W-1:0] c_idx,
                            input logic signed [ELEM_W-1:0] c_val, input logic c_last);
      if (c_cmd == CMD_LOAD) begin
        weight[c_row][c_col][c_idx] = c_val;
      end else begin
        sample[c_idx] = c_val;
        if (c_last) pending_winners.push_back(nearest_neuron());
      end
    endfunction

    task log_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    // accepted output transaction
    task match_winner(input logic [ROW_W-1:0] got_row,
                      input logic [COL_W-1:0] got_col,
                      input logic [DIST_W-1:0] got_dist);
      winner_t want;
      if (pending_winners.size() == 0) begin
        log_mismatch($sformatf("result (%0d,%0d) %0d with no search pending",
                               got_row, got_col, got_dist));
        return;
      end
      want = pending_winners.pop_front();
      if (got_row !== want.row)
        log_mismatch($sformatf("winner_row %0d, want %0d", got_row, want.row));
      if (got_col !== want.col)
        log_mismatch($sformatf("winner_col %0d, want %0d", got_col, want.col));
      if (got_dist !== want.distance)
        log_mismatch($sformatf("best_distance %0d, want %0d", got_dist, want.distance));
    endtask

    function int unsigned outstanding();
      return pending_winners.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic                         cmd;
  logic [ROW_W-1:0]             neuron_row;
  logic [COL_W-1:0]             neuron_col;
  logic [IDX_W-1:0]             element_index;
  logic signed [ELEM_W-1:0]     element_value;
  logic                         last_element;
  logic                         out_valid;
  logic                         out_stall;
  logic [ROW_W-1:0]             winner_row;
  logic [COL_W-1:0]             winner_col;
  logic [DIST_W-1:0]            best_distance;

  winner_board board;
  bit          w_written [MAX_ROWS][MAX_COLS][MAX_LEN];
  bit          s_written [MAX_LEN];
  bit          in_burst;
  bit          out_burst;

  som_best_matching_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .neuron_row    (neuron_row),
    .neuron_col    (neuron_col),
    .element_index (element_index),
    .element_value (element_value),
    .last_element  (last_element),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .winner_row    (winner_row),
    .winner_col    (winner_col),
    .best_distance (best_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // element values: full range, extremes, or small values that tie often
  function automatic logic signed [ELEM_W-1:0] pick_value(input int unsigned mode);
    case (mode)
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return int'($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  // One input transaction; valid stays high afterwards so back-to-back items need no gap
  task automatic send_item(input logic c_cmd, input logic [ROW_W-1:0] c_row,
                           input logic [COL_W-1:0] c_col, input logic [IDX_W-1:0] c_idx,
                           input logic signed [ELEM_W-1:0] c_val, input logic c_last);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c_cmd;
    neuron_row    <= c_row;
    neuron_col    <= c_col;
    element_index <= c_idx;
    element_value <= c_val;
    last_element  <= c_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_item(c_cmd, c_row, c_col, c_idx, c_val, c_last);
    if (c_cmd == CMD_LOAD) w_written[c_row][c_col][c_idx] = 1'b1;
    else s_written[c_idx] = 1'b1;
  endtask

  // Register writes, only while the block is idle
  task automatic set_map(input logic [CFG_DATA_W-1:0] rows_raw,
                         input logic [CFG_DATA_W-1:0] cols_raw,
                         input logic [CFG_DATA_W-1:0] len_raw);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAP_ROWS;
    cfg_data  <= rows_raw;
    @(posedge clk);
    board.set_reg(CFG_MAP_ROWS, rows_raw);
    cfg_index <= CFG_MAP_COLS;
    cfg_data  <= cols_raw;
    @(posedge clk);
    board.set_reg(CFG_MAP_COLS, cols_raw);
    cfg_index <= CFG_VECTOR_LENGTH;
    cfg_data  <= len_raw;
    @(posedge clk);
    board.set_reg(CFG_VECTOR_LENGTH, len_raw);
    cfg_index <= CFG_SPARE;
    cfg_data  <= junk;
    @(posedge clk);
    board.set_reg(CFG_SPARE, junk);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every predicted winner, then let the pipeline settle
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One sample sequence: stray loads, weight fill, a tie copy, then sample elements
  task automatic run_sequence(input seq_kind_t kind_in);
    seq_kind_t             kind;
    int unsigned           nr, nc, nl, vmode, cnt, a_r, a_c, b_r, b_c;
    int                    order [MAX_LEN];
    int                    j, tmp;
    bit                    all_samples, late_last;
    logic signed [ELEM_W-1:0] ext, val;
    kind  = kind_in;
    nr    = board.rows_used;
    nc    = board.cols_used;
    nl    = board.len_used;
    vmode = $urandom_range(0, 2);
    ext   = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    in_burst = ($urandom_range(0, 4) == 0);
    if (kind == SEQ_EXTREME && nr * nc * nl > 64) kind = SEQ_PLAIN;
    if (kind == SEQ_TIE && nr * nc < 2) kind = SEQ_COPY;

    // stray loads anywhere, last mark random (ignored on loads)
    repeat ($urandom_range(0, 3))
      send_item(CMD_LOAD, $urandom, $urandom, $urandom, pick_value(vmode), $urandom);

    // every weight the search will read must be written
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        for (int e = 0; e < nl; e++)
          if (kind == SEQ_EXTREME || !w_written[r][c][e])
            send_item(CMD_LOAD, r, c, e,
                      (kind == SEQ_EXTREME) ? ext : pick_value(vmode), 1'b0);

    a_r = $urandom_range(0, nr - 1);
    a_c = $urandom_range(0, nc - 1);
    // second neuron gets the same vector, so both sit at distance zero
    if (kind == SEQ_TIE) begin
      do begin
        b_r = $urandom_range(0, nr - 1);
        b_c = $urandom_range(0, nc - 1);
      end while (b_r == a_r && b_c == a_c);
      for (int e = 0; e < nl; e++)
        send_item(CMD_LOAD, b_r, b_c, e, board.weight[a_r][a_c][e], 1'b0);
    end

    // shuffled element order
    for (int e = 0; e < nl; e++) order[e] = e;
    for (int i = nl - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end

    all_samples = 1'b1;
    for (int e = 0; e < nl; e++) if (!s_written[e]) all_samples = 1'b0;
    cnt = nl;
    if (kind == SEQ_PARTIAL && all_samples) cnt = $urandom_range(1, nl);
    if (kind == SEQ_ABANDON) cnt = $urandom_range(1, nl);
    late_last = (kind == SEQ_PLAIN) && ($urandom_range(0, 3) == 0);

    for (int i = 0; i < cnt; i++) begin
      // element beyond the vector length, never read by the search
      if (kind == SEQ_PLAIN && nl < MAX_LEN && $urandom_range(0, 3) == 0)
        send_item(CMD_SAMPLE, $urandom, $urandom, $urandom_range(nl, MAX_LEN - 1),
                  pick_value(vmode), 1'b0);
      case (kind)
        SEQ_EXTREME:       val = ~ext;
        SEQ_COPY, SEQ_TIE: val = board.weight[a_r][a_c][order[i]];
        default:           val = pick_value(vmode);
      endcase
      send_item(CMD_SAMPLE, $urandom, $urandom, order[i], val,
                (i == cnt - 1) && kind != SEQ_ABANDON && !late_last);
    end
    // search started by an element at any index
    if (late_last)
      send_item(CMD_SAMPLE, $urandom, $urandom, $urandom, pick_value(vmode), 1'b1);
  endtask

  // Stimulus
  initial begin
    seq_kind_t kind;
    board = new();
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_MAP_ROWS;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    cmd           <= CMD_LOAD;
    neuron_row    <= '0;
    neuron_col    <= '0;
    element_index <= '0;
    element_value <= '0;
    last_element  <= 1'b0;
    in_burst = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: one row of two neurons, one element each
    set_map(1, 2, 1);
    send_item(CMD_LOAD, 0, 0, 0, VAL_MIN, 1'b0);
    send_item(CMD_LOAD, 0, 1, 0, VAL_MAX, 1'b0);
    send_item(CMD_LOAD, 0, 1, 0, VAL_MAX, 1'b1);    // last mark on a load: no search
    send_item(CMD_SAMPLE, 0, 0, 0, VAL_MAX, 1'b1);  // exact hit on the second neuron
    send_item(CMD_SAMPLE, 0, 0, 0, VAL_MIN, 1'b1);  // exact hit on the first
    send_item(CMD_SAMPLE, 7, 7, 0, '0, 1'b1);
    send_item(CMD_SAMPLE, 7, 7, 15, 16'sh5555, 1'b0); // outside the vector in use
    send_item(CMD_LOAD, 7, 7, 15, 16'sh2AAA, 1'b0);   // outside the map in use
    // both neurons equal: first in row-major order wins, largest per-element square
    send_item(CMD_LOAD, 0, 1, 0, VAL_MIN, 1'b0);
    send_item(CMD_SAMPLE, 0, 0, 0, VAL_MAX, 1'b1);
    send_item(CMD_LOAD, 0, 0, 0, '0, 1'b0);
    send_item(CMD_LOAD, 0, 1, 0, '0, 1'b0);
    send_item(CMD_SAMPLE, 0, 0, 0, '1, 1'b1);
    quiesce();

    // random phases over several map shapes
    for (int p = 0; p < 7; p++) begin
      set_map(phase_rows[p], phase_cols[p], phase_len[p]);
      for (int s = 0; s < phase_seqs[p]; s++) begin
        case ($urandom_range(0, 19))
          0:            kind = SEQ_EXTREME;
          1, 2, 3:      kind = SEQ_COPY;
          4, 5, 6:      kind = SEQ_TIE;
          7, 8, 9:      kind = SEQ_PARTIAL;
          10, 11:       kind = SEQ_ABANDON;
          default:      kind = SEQ_PLAIN;
        endcase
        run_sequence((s == 0) ? phase_open[p] : kind);
      end
      quiesce();
    end

    if (board.errors == 0) begin
      $display("som_best_matching_unit_tb: done, clean");
    end else begin
      $display("som_best_matching_unit_tb: done, errors");
    end
    $finish;
  end

  // Result side: random stall before each output transaction
  initial begin
    int unsigned stall_cycles;
    out_stall <= 1'b0;
    out_burst = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall_cycles = out_burst ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
      if (stall_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.match_winner(winner_row, winner_col, best_distance);
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("som_best_matching_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
src/som_bmu_pkg.sv
src/som_bmu_store.sv
src/som_bmu_mac.sv
src/som_bmu_ctrl.sv
src/som_best_matching_unit.sv
bench/som_best_matching_unit_tb.sv
